>>> src/seconds_to_calendar_assert.svh
// Assertion macros for the seconds to calendar converter.
`ifndef SECONDS_TO_CALENDAR_ASSERT_SVH
`define SECONDS_TO_CALENDAR_ASSERT_SVH

// Overlapping implication, checked on every rising edge outside reset
`define S2C_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("s2cal: check failed");

// Implication into the following cycle
`define S2C_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("s2cal: check failed");

`endif

>>> src/s2cal_pkg.sv
`timescale 1ns / 1ps

package s2cal_pkg;

   // Time unit divisors
   localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
   localparam logic [31:0] SECS_PER_MIN  = 32'd60;

   // Quotient widths of the three divisions (day count, hour, minute)
   localparam int DAY_QUO_BITS  = 16;
   localparam int HOUR_QUO_BITS = 5;
   localparam int MIN_QUO_BITS  = 6;

   // Divisors aligned to the top quotient bit of each division
   localparam logic [31:0] DAY_DIV_INIT  = SECS_PER_DAY << (DAY_QUO_BITS - 1);
   localparam logic [31:0] HOUR_DIV_INIT = SECS_PER_HOUR << (HOUR_QUO_BITS - 1);
   localparam logic [31:0] MIN_DIV_INIT  = SECS_PER_MIN << (MIN_QUO_BITS - 1);

   localparam logic [10:0] FIRST_YEAR = 11'd1900;
   localparam logic [3:0]  LAST_MONTH = 4'd11;
   localparam logic [3:0]  FEBRUARY   = 4'd1;
   localparam logic [3:0]  JULY       = 4'd6;

   // Gregorian leap rule over the reachable years 1900..2036: every fourth
   // year, except the century year 1900 (2000 is a leap year, 2100 is out of reach)
   function automatic logic is_leap(input logic [10:0] year);
      return (year[1:0] == 2'b00) && (year != FIRST_YEAR);
   endfunction

   function automatic logic [8:0] year_len(input logic [10:0] year);
      return is_leap(year) ? 9'd366 : 9'd365;
   endfunction

   // Days in a zero-based month; months alternate 31/30 with a shift after July
   function automatic logic [8:0] month_len(input logic leap, input logic [3:0] month);
      logic [3:0] k;
      k = (month > JULY) ? 4'(month - 4'd1) : month;
      if (month == FEBRUARY) begin
         return leap ? 9'd29 : 9'd28;
      end
      return k[0] ? 9'd30 : 9'd31;
   endfunction

endpackage

>>> src/seconds_to_calendar.sv
// One conversion at a time: the input stalls from its transfer until the result has been handed
// to the output register, longer while that register is held off.
// A single 32-bit subtract-and-compare unit does 27 restoring-division steps, then one year
// or one month per cycle. Synchronous reset clears the sequencer and the output valid.
`timescale 1ns / 1ps
`include "seconds_to_calendar_assert.svh"

module seconds_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_seconds_since_epoch,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_year,
   output logic [3:0]  rsp_month_index,
   output logic [4:0]  rsp_day_index,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DAYDIV = 3'd1;
   localparam logic [2:0] ST_HRDIV  = 3'd2;
   localparam logic [2:0] ST_MNDIV  = 3'd3;
   localparam logic [2:0] ST_YEAR   = 3'd4;
   localparam logic [2:0] ST_MONTH  = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [15:0] quo_ff, quo_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] days_ff, days_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   logic [10:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [10:0] rsp_year_ff, rsp_year_in;
   logic [3:0]  rsp_month_ff, rsp_month_in;
   logic [4:0]  rsp_day_ff, rsp_day_in;
   logic [4:0]  rsp_hour_ff, rsp_hour_in;
   logic [5:0]  rsp_minute_ff, rsp_minute_in;
   logic [5:0]  rsp_second_ff, rsp_second_in;

   logic        leap;
   logic [31:0] opnd;
   logic [32:0] diff;
   logic        ge;
   logic [31:0] rem_step;
   logic [15:0] quo_step;
   logic        out_free;

   assign leap     = s2cal_pkg::is_leap(year_ff);
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Operand select for the shared subtractor
   always_comb begin
      unique case (state_ff) inside
         ST_DAYDIV, ST_HRDIV, ST_MNDIV: opnd = div_ff;
         ST_YEAR:  opnd = 32'(s2cal_pkg::year_len(year_ff));
         ST_MONTH: opnd = 32'(s2cal_pkg::month_len(leap, month_ff));
         default:  opnd = '0;
      endcase
   end

   // Shared subtract and compare
   assign diff     = {1'b0, rem_ff} - {1'b0, opnd};
   assign ge       = !diff[32];
   assign rem_step = ge ? diff[31:0] : rem_ff;
   assign quo_step = {quo_ff[14:0], ge};

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      days_in   = days_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rem_in   = req_seconds_since_epoch;
               div_in   = s2cal_pkg::DAY_DIV_INIT;
               quo_in   = '0;
               cnt_in   = 4'(s2cal_pkg::DAY_QUO_BITS - 1);
               state_in = ST_DAYDIV;
            end
         end
         ST_DAYDIV: begin
            rem_in = rem_step;
            quo_in = quo_step;
            div_in = div_ff >> 1;
            cnt_in = 4'(cnt_ff - 4'd1);
            if (cnt_ff == '0) begin
               days_in  = quo_step;
               quo_in   = '0;
               div_in   = s2cal_pkg::HOUR_DIV_INIT;
               cnt_in   = 4'(s2cal_pkg::HOUR_QUO_BITS - 1);
               state_in = ST_HRDIV;
            end
         end
         ST_HRDIV: begin
            rem_in = rem_step;
            quo_in = quo_step;
            div_in = div_ff >> 1;
            cnt_in = 4'(cnt_ff - 4'd1);
            if (cnt_ff == '0) begin
               hour_in  = quo_step[4:0];
               quo_in   = '0;
               div_in   = s2cal_pkg::MIN_DIV_INIT;
               cnt_in   = 4'(s2cal_pkg::MIN_QUO_BITS - 1);
               state_in = ST_MNDIV;
            end
         end
         ST_MNDIV: begin
            rem_in = rem_step;
            quo_in = quo_step;
            div_in = div_ff >> 1;
            cnt_in = 4'(cnt_ff - 4'd1);
            if (cnt_ff == '0) begin
               minute_in = quo_step[5:0];
               second_in = rem_step[5:0];
               rem_in    = 32'(days_ff);
               year_in   = s2cal_pkg::FIRST_YEAR;
               state_in  = ST_YEAR;
            end
         end
         ST_YEAR: begin
            // strip whole years
            if (ge) begin
               rem_in  = diff[31:0];
               year_in = 11'(year_ff + 11'd1);
            end else begin
               month_in = '0;
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            // strip whole months, December takes the rest
            if (ge && (month_ff != s2cal_pkg::LAST_MONTH)) begin
               rem_in   = diff[31:0];
               month_in = 4'(month_ff + 4'd1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_hour_in   = rsp_hour_ff;
      rsp_minute_in = rsp_minute_ff;
      rsp_second_in = rsp_second_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_year_in   = year_ff;
         rsp_month_in  = month_ff;
         rsp_day_in    = rem_ff[4:0];
         rsp_hour_in   = hour_ff;
         rsp_minute_in = minute_ff;
         rsp_second_in = second_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      days_ff       <= days_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      second_ff     <= second_in;
      year_ff       <= year_in;
      month_ff      <= month_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_hour_ff   <= rsp_hour_in;
      rsp_minute_ff <= rsp_minute_in;
      rsp_second_ff <= rsp_second_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_year        = rsp_year_ff;
   assign rsp_month_index = rsp_month_ff;
   assign rsp_day_index   = rsp_day_ff;
   assign rsp_hour        = rsp_hour_ff;
   assign rsp_minute      = rsp_minute_ff;
   assign rsp_second      = rsp_second_ff;

   // Checks
   `S2C_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `S2C_ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid), $past(state_ff == ST_DONE))
   `S2C_ASSERT_SAME(a_year_range, clock, reset, state_ff == ST_YEAR, year_ff <= 11'd2036)
   `S2C_ASSERT_SAME(a_hour_range, clock, reset, rsp_valid, rsp_hour <= 5'd23)

endmodule
